// ===== rtl/core/lom_pkg.sv =====
// Shared types and constants for the limit order matcher.
// Used by the cell, the core and the checker.
package lom_pkg;

    localparam int ORDER_SLOTS = 32;
    localparam int SLOT_W      = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
    localparam int TRADE_CAP   = 32;
    localparam int TRD_W       = $clog2(TRADE_CAP + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;

    localparam logic [1:0] TYPE_GTC = 2'd0;
    localparam logic [1:0] TYPE_IOC = 2'd1;
    localparam logic [1:0] TYPE_FOK = 2'd2;

    localparam logic [2:0] ST_TRADE     = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] order_id;
        logic        is_sell;
        logic [15:0] limit_price;
        logic [31:0] order_quantity;
        logic [1:0]  order_kind;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [15:0] trade_price;
        logic [31:0] trade_quantity;
        logic        last;
    } t_out_item;

    // best order of one side seen so far along the chain
    typedef struct packed {
        logic              v;
        logic [SLOT_W-1:0] idx;
        logic [15:0]       price;
        logic [31:0]       arrival;
        logic [31:0]       id;
        logic [31:0]       rem;
    } t_cand;

    typedef struct packed {
        t_cand             bid;
        t_cand             ask;
        logic              found;
        logic [SLOT_W-1:0] found_idx;
        logic [1:0]        found_type;
        logic              free_v;
        logic [SLOT_W-1:0] free_idx;
        logic [32:0]       avail;   // saturates at 2^32
    } t_carry;

    typedef struct packed {
        logic [31:0] id;
        logic        is_sell;
        logic [15:0] price;
    } t_query;

    typedef struct packed {
        logic              ins_en;
        logic [SLOT_W-1:0] ins_idx;
        logic [31:0]       ins_id;
        logic [15:0]       ins_price;
        logic [31:0]       ins_rem;
        logic              ins_sell;
        logic [1:0]        ins_type;
        logic [31:0]       ins_arrival;
        logic              updb_en;
        logic [SLOT_W-1:0] updb_idx;
        logic [31:0]       updb_rem;
        logic              upda_en;
        logic [SLOT_W-1:0] upda_idx;
        logic [31:0]       upda_rem;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_idx;
    } t_cmd;

endpackage

// ===== rtl/core/lom_cell.sv =====
// One order slot of the book plus its stage of the scan chain.
// Depends on lom_pkg.
module lom_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [lom_pkg::SLOT_W-1:0] i_slot_idx,
    input  lom_pkg::t_query      i_query,
    input  lom_pkg::t_cmd        i_cmd,
    input  lom_pkg::t_carry      i_carry,
    output lom_pkg::t_carry      o_carry
);
    import lom_pkg::*;

    logic        r_valid;
    logic        r_sell;
    logic [1:0]  r_type;
    logic [31:0] r_id;
    logic [15:0] r_price;
    logic [31:0] r_rem;
    logic [31:0] r_arrival;
    t_carry      r_carry;
    t_carry      n_carry;
    t_cand       w_mine;
    logic        w_cross;
    logic [33:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_en && i_cmd.ins_idx == i_slot_idx) begin
                r_valid <= 1'b1;
            end else if (i_cmd.clr_en && i_cmd.clr_idx == i_slot_idx) begin
                r_valid <= 1'b0;
            end else if (i_cmd.updb_en && i_cmd.updb_idx == i_slot_idx
                         && i_cmd.updb_rem == 32'd0) begin
                r_valid <= 1'b0;
            end else if (i_cmd.upda_en && i_cmd.upda_idx == i_slot_idx
                         && i_cmd.upda_rem == 32'd0) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en && i_cmd.ins_idx == i_slot_idx) begin
            r_sell    <= i_cmd.ins_sell;
            r_type    <= i_cmd.ins_type;
            r_id      <= i_cmd.ins_id;
            r_price   <= i_cmd.ins_price;
            r_rem     <= i_cmd.ins_rem;
            r_arrival <= i_cmd.ins_arrival;
        end else if (i_cmd.updb_en && i_cmd.updb_idx == i_slot_idx) begin
            r_rem <= i_cmd.updb_rem;
        end else if (i_cmd.upda_en && i_cmd.upda_idx == i_slot_idx) begin
            r_rem <= i_cmd.upda_rem;
        end
        r_carry <= n_carry;
    end

    always_comb begin
        w_mine.v       = 1'b1;
        w_mine.idx     = i_slot_idx;
        w_mine.price   = r_price;
        w_mine.arrival = r_arrival;
        w_mine.id      = r_id;
        w_mine.rem     = r_rem;
        w_cross = i_query.is_sell ? (r_price >= i_query.price) : (r_price <= i_query.price);
        w_sum   = {1'b0, i_carry.avail} + {2'b00, r_rem};

        n_carry = i_carry;
        // strict improvement only: equal prices go to the earlier arrival, full ties keep the lower slot
        if (r_valid && !r_sell) begin
            if (!i_carry.bid.v || r_price > i_carry.bid.price
                || (r_price == i_carry.bid.price && r_arrival < i_carry.bid.arrival)) begin
                n_carry.bid = w_mine;
            end
        end
        if (r_valid && r_sell) begin
            if (!i_carry.ask.v || r_price < i_carry.ask.price
                || (r_price == i_carry.ask.price && r_arrival < i_carry.ask.arrival)) begin
                n_carry.ask = w_mine;
            end
        end
        if (r_valid && r_id == i_query.id && !i_carry.found) begin
            n_carry.found      = 1'b1;
            n_carry.found_idx  = i_slot_idx;
            n_carry.found_type = r_type;
        end
        if (!r_valid && !i_carry.free_v) begin
            n_carry.free_v   = 1'b1;
            n_carry.free_idx = i_slot_idx;
        end
        if (r_valid && r_sell != i_query.is_sell && w_cross) begin
            n_carry.avail = (w_sum[33:32] != 2'b00) ? 33'h1_0000_0000 : w_sum[32:0];
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== rtl/core/limit_order_matcher_core.sv =====
// Limit order book with price-time priority: slot cells chained into a scan
// pipeline, plus the message sequencer and output register. Depends on lom_pkg, lom_cell.
//
//  channel | direction | valid   | stall   | payload
//  input   | in        | i_valid | o_stall | i_item (t_in_item)
//  output  | out       | o_valid | i_stall | o_item (t_out_item)
//
// Every scan of the book runs through the registered cell chain.
// Reset is synchronous, active low, and clears all slots.
// Output stall holds the sequencer before each item it emits; input stall is high
// while a message is in work.
module limit_order_matcher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lom_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output lom_pkg::t_out_item  o_item
);
    import lom_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_MATCH = 3'd3;
    localparam logic [2:0] S_TRADE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    t_in_item          r_item;
    logic [CNT_W-1:0]  r_wait;
    logic [31:0]       r_arrival, n_arrival;
    logic [1:0]        r_type, n_type;
    logic [SLOT_W-1:0] r_new_idx, n_new_idx;
    logic [TRD_W-1:0]  r_trades, n_trades;
    logic [2:0]        r_status, n_status;
    t_out_item         r_trade, n_trade;
    logic              r_out_v;
    t_out_item         r_out;

    t_carry            w_carry [0:ORDER_SLOTS];
    t_carry            w_res;
    t_query            w_query;
    t_cmd              w_cmd;
    logic              w_out_free;
    logic              w_out_load;
    t_out_item         w_out_data;
    t_cand             w_opp;
    logic              w_opp_cross;
    logic [31:0]       w_q;

    assign w_carry[0] = '0;
    assign w_res      = w_carry[ORDER_SLOTS];

    assign w_query.id      = r_item.order_id;
    assign w_query.is_sell = r_item.is_sell;
    assign w_query.price   = r_item.limit_price;

    for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
        lom_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_slot_idx (SLOT_W'(g)),
            .i_query    (w_query),
            .i_cmd      (w_cmd),
            .i_carry    (w_carry[g]),
            .o_carry    (w_carry[g+1])
        );
    end

    assign w_out_free = !r_out_v || !i_stall;
    assign w_opp      = r_item.is_sell ? w_res.bid : w_res.ask;
    assign w_opp_cross = w_opp.v && (r_item.is_sell ? (w_opp.price >= r_item.limit_price)
                                                    : (w_opp.price <= r_item.limit_price));
    assign w_q = (w_res.bid.rem < w_res.ask.rem) ? w_res.bid.rem : w_res.ask.rem;

    always_comb begin
        n_state    = r_state;
        n_arrival  = r_arrival;
        n_type     = r_type;
        n_new_idx  = r_new_idx;
        n_trades   = r_trades;
        n_status   = r_status;
        n_trade    = r_trade;
        w_cmd      = '0;
        w_out_load = 1'b0;
        w_out_data = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                    n_type  = i_item.order_kind;
                end
            end
            S_LOOK: begin
                if (r_wait == '0) begin
                    case (r_item.kind)
                        KIND_ADD: begin
                            n_state = S_ADD;
                        end
                        KIND_CANCEL: begin
                            n_state = S_DONE;
                            if (w_res.found) begin
                                w_cmd.clr_en  = 1'b1;
                                w_cmd.clr_idx = w_res.found_idx;
                                n_status      = ST_CANCELLED;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        KIND_MODIFY: begin
                            if (w_res.found) begin
                                w_cmd.clr_en  = 1'b1;
                                w_cmd.clr_idx = w_res.found_idx;
                                n_type        = w_res.found_type;
                                n_state       = S_ADD;
                            end else begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_status = ST_REJECTED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (r_wait == '0) begin
                    n_state = S_DONE;
                    if (r_item.order_quantity == 32'd0 || r_item.order_id == 32'd0
                        || w_res.found || r_type > TYPE_FOK) begin
                        n_status = ST_REJECTED;
                    end else if (!w_res.free_v) begin
                        n_status = ST_FULL;
                    end else if (r_type == TYPE_IOC && !w_opp_cross) begin
                        n_status = ST_REJECTED;
                    end else if (r_type == TYPE_FOK
                                 && w_res.avail < {1'b0, r_item.order_quantity}) begin
                        n_status = ST_REJECTED;
                    end else begin
                        w_cmd.ins_en      = 1'b1;
                        w_cmd.ins_idx     = w_res.free_idx;
                        w_cmd.ins_id      = r_item.order_id;
                        w_cmd.ins_price   = r_item.limit_price;
                        w_cmd.ins_rem     = r_item.order_quantity;
                        w_cmd.ins_sell    = r_item.is_sell;
                        w_cmd.ins_type    = r_type;
                        w_cmd.ins_arrival = r_arrival;
                        n_arrival         = r_arrival + 32'd1;
                        n_new_idx         = w_res.free_idx;
                        n_trades          = '0;
                        n_state           = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                if (r_wait == '0) begin
                    if (r_trades < TRD_W'(TRADE_CAP) && w_res.bid.v && w_res.ask.v
                        && w_res.bid.price >= w_res.ask.price) begin
                        w_cmd.updb_en  = 1'b1;
                        w_cmd.updb_idx = w_res.bid.idx;
                        w_cmd.updb_rem = w_res.bid.rem - w_q;
                        w_cmd.upda_en  = 1'b1;
                        w_cmd.upda_idx = w_res.ask.idx;
                        w_cmd.upda_rem = w_res.ask.rem - w_q;
                        n_trade.status         = ST_TRADE;
                        n_trade.buyer_id       = w_res.bid.id;
                        n_trade.seller_id      = w_res.ask.id;
                        n_trade.trade_price    = w_res.ask.price;
                        n_trade.trade_quantity = w_q;
                        n_trade.last           = 1'b0;
                        n_state = S_TRADE;
                    end else begin
                        // IOC/FOK remainder leaves the book; harmless if already gone
                        if (r_type != TYPE_GTC) begin
                            w_cmd.clr_en  = 1'b1;
                            w_cmd.clr_idx = r_new_idx;
                        end
                        n_status = ST_ACCEPTED;
                        n_state  = S_DONE;
                    end
                end
            end
            S_TRADE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_data = r_trade;
                    n_trades   = r_trades + TRD_W'(1);
                    n_state    = S_MATCH;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load        = 1'b1;
                    w_out_data.status = r_status;
                    w_out_data.last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wait    <= CNT_W'(ORDER_SLOTS);
            r_arrival <= '0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_arrival <= n_arrival;
            // r_wait counts down until the chain output is current after the last
            // slot write or query change
            if (w_cmd.ins_en || w_cmd.clr_en || w_cmd.updb_en || w_cmd.upda_en
                || (r_state == S_IDLE && i_valid)) begin
                r_wait <= CNT_W'(ORDER_SLOTS);
            end else if (r_wait != '0) begin
                r_wait <= r_wait - CNT_W'(1);
            end
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_item;
        end
        if (w_out_load) begin
            r_out <= w_out_data;
        end
        r_type    <= n_type;
        r_new_idx <= n_new_idx;
        r_trades  <= n_trades;
        r_status  <= n_status;
        r_trade   <= n_trade;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

// ===== rtl/core/lom_checker.sv =====
// Port-level assertions for limit_order_matcher_core, bound into that module.
// Depends on lom_pkg.
module lom_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input lom_pkg::t_out_item o_item
);
    import lom_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output item changed under stall");

    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not held off after an accepted item");

    a_close_not_trade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last |-> o_item.status != ST_TRADE)
        else $error("closing item carries trade status");

    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last |-> o_item.buyer_id == 32'd0 && o_item.seller_id == 32'd0
                                   && o_item.trade_quantity == 32'd0)
        else $error("closing item has trade fields");

    a_trade_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last |-> o_item.status == ST_TRADE
                                    && o_item.trade_quantity != 32'd0)
        else $error("trade item malformed");

endmodule

bind limit_order_matcher_core lom_checker u_lom_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
